// ===== rtl/hsv_to_rgb_converter_assert.svh =====
// ---------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared property wrappers for the converter checker, clocked on clock.
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Check a property outside of reset.
`define HSVRGB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every edge, reset included.
`define HSVRGB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/hsvrgb_pkg.sv =====
// ---------------------------------------------------------------------------
// HSV to RGB converter package
// Constants, payload widths and per-channel helpers for the converter.
// ---------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

   // Payload widths
   localparam int unsigned HUE_W   = 9;
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned REQ_W   = 40;
   localparam int unsigned RSP_W   = 32;
   localparam int unsigned NUM_CH  = 3;
   localparam int unsigned STAGES  = 4;

   // Angle constants in degrees
   localparam int unsigned TURN_DEG    = 360;
   localparam int unsigned SEXTANT_DEG = 60;
   localparam int unsigned FLAT_DEG    = 120;
   localparam int unsigned FALL_DEG    = 180;
   localparam int unsigned ZERO_DEG    = 240;

   // Full-scale denominator: 255 * 60
   localparam int unsigned DEN      = 15300;
   localparam int unsigned DEN_W    = 14;
   localparam int unsigned NUM_W    = 22;

   // Reciprocal of DEN, rounded up; exact for every numerator below 2^22
   localparam int unsigned RECIP_SHIFT = 36;
   localparam int unsigned RECIP_W     = 23;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN));
   localparam int unsigned PROD_W = NUM_W + RECIP_W;

   // Hue offsets for red, green, blue
   localparam logic [HUE_W-1:0] CH_OFFSET [NUM_CH] = '{9'd300, 9'd180, 9'd60};

   // Wrap (hue + offset) into 0..359
   function automatic logic [HUE_W-1:0] wrap_hue(input logic [HUE_W-1:0] hue,
                                                 input logic [HUE_W-1:0] offset);
      logic [HUE_W:0] sum;
      logic [HUE_W:0] res;
      sum = {1'b0, hue} + {1'b0, offset};
      priority if (sum >= 10'(2 * TURN_DEG)) begin
         res = sum - 10'(2 * TURN_DEG);
      end else if (sum >= 10'(TURN_DEG)) begin
         res = sum - 10'(TURN_DEG);
      end else begin
         res = sum;
      end
      return res[HUE_W-1:0];
   endfunction

   // Ramp weight: clamp(min(x, 240 - x), 0, 60)
   function automatic logic [5:0] ramp_weight(input logic [HUE_W-1:0] x);
      logic [5:0] w;
      priority if (x <= 9'(FLAT_DEG)) begin
         w = (x >= 9'(SEXTANT_DEG)) ? 6'(SEXTANT_DEG) : x[5:0];
      end else if (x >= 9'(ZERO_DEG)) begin
         w = '0;
      end else if (x >= 9'(FALL_DEG)) begin
         w = 6'(9'(ZERO_DEG) - x);
      end else begin
         w = 6'(SEXTANT_DEG);
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
// ---------------------------------------------------------------------------
// HSV to RGB converter
// Converts one HSV pixel with alpha into 8-bit red, green and blue.
// ---------------------------------------------------------------------------
// Usage:
//   Input items arrive on the req_ stream (hue, saturation, brightness,
//   alpha); each produces exactly one result item on the rsp_ stream
//   (red, green, blue, alpha copied through). Hue codes 360..511 wrap.
//   rsp_tvalid rises once the item has passed the four register stages:
//   hue wrap, ramp weight times saturation, brightness multiply and
//   reciprocal divide by 15300. Each stage holds at most one pixel, so
//   throughput is one item per cycle while the receiver does not stall.
//   When the receiver stalls, each stage holds its item and stages behind
//   it keep filling bubbles; req_tready drops only once every stage ahead
//   of the input is occupied. Nothing is lost or repeated.
//   Synchronous reset empties the pipeline; req_tready is high right after.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Input item
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [8:0] hue_deg, [16:9] saturation, [24:17] brightness, [32:25] alpha_in
   input  wire logic [hsvrgb_pkg::REQ_W-1:0]  req_tdata,
   // Result item
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha_out
   output logic      [hsvrgb_pkg::RSP_W-1:0]  rsp_tdata
);

   localparam int unsigned HW = hsvrgb_pkg::HUE_W;
   localparam int unsigned CW = hsvrgb_pkg::CHAN_W;
   localparam int unsigned NC = hsvrgb_pkg::NUM_CH;
   localparam int unsigned ST = hsvrgb_pkg::STAGES;

   // Stage valid bits and per-stage load enables
   logic [ST-1:0] vld_ff;
   logic [ST-1:0] vld_in;
   logic [ST:0]   rdy;

   // Stage 0: wrapped hue per channel
   logic [HW-1:0] x_ff     [NC];
   logic [HW-1:0] x_in     [NC];
   logic [CW-1:0] sat0_ff;
   logic [CW-1:0] val0_ff;
   logic [CW-1:0] alpha0_ff;

   // Stage 1: factor 15300 - sat * weight
   logic [hsvrgb_pkg::DEN_W-1:0] d_ff [NC];
   logic [hsvrgb_pkg::DEN_W-1:0] d_in [NC];
   logic [CW-1:0] val1_ff;
   logic [CW-1:0] alpha1_ff;

   // Stage 2: numerator brightness * factor
   logic [hsvrgb_pkg::NUM_W-1:0] num_ff [NC];
   logic [hsvrgb_pkg::NUM_W-1:0] num_in [NC];
   logic [CW-1:0] alpha2_ff;

   // Stage 3: quotient, drives the result port
   logic [hsvrgb_pkg::PROD_W-1:0] prod   [NC];
   logic [CW-1:0]                 chan_ff [NC];
   logic [CW-1:0]                 chan_in [NC];
   logic [CW-1:0]                 alpha3_ff;

   // Ready chain: a stage loads when empty or when the next one loads
   always_comb begin
      rdy[ST] = rsp_tready;
      for (int s = ST - 1; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
   end

   assign req_tready = rdy[0];

   // Advance valid bits
   always_comb begin
      vld_in = vld_ff;
      if (rdy[0]) begin
         vld_in[0] = req_tvalid;
      end
      for (int s = 1; s < ST; s++) begin
         if (rdy[s]) begin
            vld_in[s] = vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Per-channel datapath
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         x_in[c]    = hsvrgb_pkg::wrap_hue(req_tdata[HW-1:0], hsvrgb_pkg::CH_OFFSET[c]);
         d_in[c]    = hsvrgb_pkg::DEN_W'(hsvrgb_pkg::DEN)
                      - (hsvrgb_pkg::DEN_W'(sat0_ff)
                         * hsvrgb_pkg::DEN_W'(hsvrgb_pkg::ramp_weight(x_ff[c])));
         num_in[c]  = hsvrgb_pkg::NUM_W'(val1_ff) * hsvrgb_pkg::NUM_W'(d_ff[c]);
         prod[c]    = hsvrgb_pkg::PROD_W'(num_ff[c]) * hsvrgb_pkg::PROD_W'(hsvrgb_pkg::RECIP);
         chan_in[c] = prod[c][hsvrgb_pkg::RECIP_SHIFT +: CW];
      end
   end

   // Payload registers, each held while its stage stalls
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         x_ff      <= x_in;
         sat0_ff   <= req_tdata[HW +: CW];
         val0_ff   <= req_tdata[HW+CW +: CW];
         alpha0_ff <= req_tdata[HW+2*CW +: CW];
      end
      if (rdy[1]) begin
         d_ff      <= d_in;
         val1_ff   <= val0_ff;
         alpha1_ff <= alpha0_ff;
      end
      if (rdy[2]) begin
         num_ff    <= num_in;
         alpha2_ff <= alpha1_ff;
      end
      if (rdy[3]) begin
         chan_ff   <= chan_in;
         alpha3_ff <= alpha2_ff;
      end
   end

   // Result item
   assign rsp_tvalid = vld_ff[ST-1];
   assign rsp_tdata  = {alpha3_ff, chan_ff[2], chan_ff[1], chan_ff[0]};

endmodule

`default_nettype wire

// ===== rtl/hsvrgb_checker.sv =====
// ---------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level properties of the converter, attached to the top level by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsvrgb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [hsvrgb_pkg::RSP_W-1:0]  rsp_tdata
);

   // Stalled result holds its item
   `HSVRGB_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result item changed while stalled")

   // Reset empties the pipeline and opens the input
   `HSVRGB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid && req_tready, "pipeline not empty after reset")

   // Input stalls only when the output stage is full and blocked
   `HSVRGB_ASSERT(a_no_false_stall, (!rsp_tvalid || rsp_tready) |-> req_tready, "input stalled with output free")

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== bench/tb_hsv_to_rgb_converter.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// HSV to RGB converter testbench
// Streams directed and random HSV pixels into the converter under random
// gaps and output back-pressure, including one long receiver hold-off. Each
// result is checked field by field against an in-bench integer model of the
// conversion.
// ---------------------------------------------------------------------------

module tb_hsv_to_rgb_converter;

   localparam int unsigned CLK_HALF      = 5;
   localparam int unsigned RESET_CYCLES  = 6;
   localparam int unsigned RANDOM_PIXELS = 1100;
   localparam int unsigned IDLE_PCT      = 7;
   localparam int unsigned CALM_FIRST    = 150;
   localparam int unsigned CALM_LAST     = 450;
   localparam int unsigned HOLD_AT       = 600;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned DRAIN_CYCLES  = 12;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned REPORT_MAX    = 10;

   // Hue shift per channel, in degrees
   localparam int unsigned RED_SHIFT   = 300;
   localparam int unsigned GREEN_SHIFT = 180;
   localparam int unsigned BLUE_SHIFT  = 60;

   // Item fields, lowest bits last so the packing matches the tdata layout
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] val;
      logic [7:0] sat;
      logic [8:0] hue;
   } hsv_pixel_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgba_type;

   // -------------------------------------------------------------------------
   // Scoreboard: converts accepted pixels and checks results in order
   // -------------------------------------------------------------------------
   class rgb_scoreboard;
      rgba_type    pending_rgba[$];
      int unsigned noted;
      int unsigned checked;
      int unsigned mismatches;

      function new();
         noted      = 0;
         checked    = 0;
         mismatches = 0;
      endfunction

      // One channel: brightness scaled down by saturation times ramp weight
      static function logic [7:0] channel_level(int unsigned hue, int unsigned sat,
                                                int unsigned val, int unsigned shift);
         int unsigned angle;
         int          fall;
         int          weight;
         int unsigned num;
         angle  = (shift + hue) % hsvrgb_pkg::TURN_DEG;
         fall   = 240 - int'(angle);
         weight = (int'(angle) < fall) ? int'(angle) : fall;
         if (weight > 60) begin
            weight = 60;
         end
         if (weight < 0) begin
            weight = 0;
         end
         num = val * (hsvrgb_pkg::DEN - sat * int'(weight));
         return 8'(num / hsvrgb_pkg::DEN);
      endfunction

      function rgba_type convert_pixel(hsv_pixel_type p);
         rgba_type c;
         c.red   = channel_level(p.hue, p.sat, p.val, RED_SHIFT);
         c.green = channel_level(p.hue, p.sat, p.val, GREEN_SHIFT);
         c.blue  = channel_level(p.hue, p.sat, p.val, BLUE_SHIFT);
         c.alpha = p.alpha;
         return c;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= REPORT_MAX) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
      endfunction

      function void note_pixel(hsv_pixel_type p);
         pending_rgba.push_back(convert_pixel(p));
         noted++;
      endfunction

      function void check_result(rgba_type got);
         rgba_type want;
         if (pending_rgba.size() == 0) begin
            flag($sformatf("result %h arrived with nothing pending", got));
            return;
         end
         want = pending_rgba.pop_front();
         checked++;
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.alpha !== want.alpha) begin
            flag($sformatf("result %0d r/g/b/a expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           checked, want.red, want.green, want.blue, want.alpha,
                           got.red, got.green, got.blue, got.alpha));
         end
      endfunction

      function int unsigned outstanding();
         return pending_rgba.size();
      endfunction

      function void flush_leftover();
         if (pending_rgba.size() != 0) begin
            flag($sformatf("%0d results never arrived", pending_rgba.size()));
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [hsvrgb_pkg::REQ_W-1:0]  req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [hsvrgb_pkg::RSP_W-1:0]  rsp_tdata;

   rgb_scoreboard     sb = new();
   bit                calm = 1'b0;
   int unsigned       wrapped_hues = 0;
   int unsigned       input_stalls = 0;
   int unsigned       cycle_count  = 0;

   always #(CLK_HALF) clock = ~clock;

   hsv_to_rgb_converter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic hsv_pixel_type make_pixel(int unsigned hue, int unsigned sat,
                                                int unsigned val, int unsigned alpha);
      hsv_pixel_type p;
      p.hue   = 9'(hue);
      p.sat   = 8'(sat);
      p.val   = 8'(val);
      p.alpha = 8'(alpha);
      return p;
   endfunction

   // Extremes show up more often than a flat draw would give them
   function automatic int unsigned random_level();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         return 0;
      end else if (pick < 20) begin
         return 255;
      end
      return $urandom_range(255);
   endfunction

   function automatic hsv_pixel_type random_pixel();
      int unsigned hue;
      if ($urandom_range(99) < 15) begin
         hue = $urandom_range(511, 360);
      end else begin
         hue = $urandom_range(359);
      end
      return make_pixel(hue, random_level(), random_level(), $urandom_range(255));
   endfunction

   // Offer one pixel, entered and left at a falling edge; random gaps first
   task automatic send_pixel(hsv_pixel_type p);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= hsvrgb_pkg::REQ_W'(p);
      do begin
         @(posedge clock);
      end while (req_tready !== 1'b1);
      sb.note_pixel(p);
      if (p.hue >= hsvrgb_pkg::TURN_DEG) begin
         wrapped_hues++;
      end
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random back-pressure plus one long hold-off to fill the pipe
   // -------------------------------------------------------------------------
   initial begin
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && sb.checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Check accepted results and count input back-pressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            sb.check_result(rgba_type'(rsp_tdata));
         end
         if (req_tvalid && req_tready !== 1'b1) begin
            input_stalls++;
         end
      end
   end

   // Abort on a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.outstanding());
      $display("FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      hsv_pixel_type directed[$];

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Sextant borders, hue wrap, zero saturation and zero brightness
      directed.push_back(make_pixel(0,   255, 255, 255));
      directed.push_back(make_pixel(59,  255, 255, 0));
      directed.push_back(make_pixel(60,  255, 255, 255));
      directed.push_back(make_pixel(61,  200, 255, 128));
      directed.push_back(make_pixel(119, 255, 255, 255));
      directed.push_back(make_pixel(120, 255, 255, 255));
      directed.push_back(make_pixel(121, 128, 200, 1));
      directed.push_back(make_pixel(180, 255, 255, 255));
      directed.push_back(make_pixel(239, 255, 255, 254));
      directed.push_back(make_pixel(240, 255, 255, 255));
      directed.push_back(make_pixel(241, 100, 100, 255));
      directed.push_back(make_pixel(300, 255, 255, 255));
      directed.push_back(make_pixel(359, 255, 255, 170));
      directed.push_back(make_pixel(360, 255, 255, 85));
      directed.push_back(make_pixel(419, 255, 128, 255));
      directed.push_back(make_pixel(480, 77,  255, 255));
      directed.push_back(make_pixel(511, 255, 255, 255));
      directed.push_back(make_pixel(200, 0,   173, 42));
      directed.push_back(make_pixel(33,  0,   255, 255));
      directed.push_back(make_pixel(90,  255, 0,   255));
      directed.push_back(make_pixel(511, 0,   0,   0));
      directed.push_back(make_pixel(256, 1,   1,   255));
      directed.push_back(make_pixel(30,  127, 128, 127));
      directed.push_back(make_pixel(150, 255, 1,   255));

      foreach (directed[i]) begin
         send_pixel(directed[i]);
      end

      // Random pixels, with one stretch free of gaps and stalls
      for (int unsigned i = 0; i < RANDOM_PIXELS; i++) begin
         calm = (i >= CALM_FIRST && i < CALM_LAST);
         send_pixel(random_pixel());
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // Drain the pipeline and watch for stray results
      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.flush_leftover();

      $display("converted %0d pixels (%0d with hue codes above 359), %0d mismatches",
               sb.checked, wrapped_hues, sb.mismatches);
      $display("input held off for %0d cycles under output back-pressure", input_stalls);
      if (sb.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
